// ===== src/srrw_pkg.sv =====
// Shared types and constants for the selective-repeat receive window.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  localparam int SEQ_W            = 16;
  localparam int ALU_W            = SEQ_W + 1;
  localparam int CFG_W            = 4;
  localparam int KIND_W           = 2;
  localparam int WIN_MAX_DEF      = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(4);
  localparam logic [SEQ_W-1:0] EXPECTED_RESET = SEQ_W'(1);

  localparam logic [KIND_W-1:0] KIND_DELIVER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TERM_ACK = 2'd2;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_TERM = 1'b1;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
  } alu_req_t;

endpackage

`default_nettype wire

// ===== src/srrw_if.sv =====
// Handshake channels of the receive window: segment in, result out, config write.
// Depends on srrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srrw_seg_if #(
  parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
);
  import srrw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [SEQ_W-1:0]        seq_num;
  logic [PAYLOAD_BITS-1:0] payload;
  logic                    checksum_ok;
  modport source (output valid, req_type, seq_num, payload, checksum_ok, input ready);
  modport sink   (input valid, req_type, seq_num, payload, checksum_ok, output ready);
endinterface

interface srrw_res_if #(
  parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
);
  import srrw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       result_kind;
  logic [SEQ_W-1:0]        result_seq;
  logic [PAYLOAD_BITS-1:0] result_data;
  logic                    conn_done;
  logic                    last_of_run;
  modport source (output valid, result_kind, result_seq, result_data, conn_done,
                  last_of_run, input ready);
  modport sink   (input valid, result_kind, result_seq, result_data, conn_done,
                  last_of_run, output ready);
endinterface

interface srrw_cfg_if;
  import srrw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_size;
  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

`default_nettype wire

// ===== src/selective_repeat_receive_window_core.sv =====
// Selective-repeat receive window: sequencer, window state and result register.
// Depends on srrw_pkg, srrw_if, srrw_alu, srrw_buf.
//
// Usage:
//   seg : segment transactions (req_type, seq_num, payload, checksum_ok).
//   res : result transactions (result_kind, result_seq, result_data,
//         conn_done, last_of_run); last_of_run marks the final result of a segment.
//   cfg : window_size writes, always ready; write only while the block is idle.
// Sequencer states a segment passes through after it is accepted:
//   bad checksum or connection finished : stays idle, no result
//   terminate segment                   : TERM
//   stale data segment (re-ack)         : CMP_LO, ACK
//   segment beyond the window           : CMP_LO, CMP_HI, no result
//   data segment in window              : CMP_LO to SLOT_WRAP, n deliveries, ACK
// Sequence compares and the store slot index use one 17-bit add/subtract unit;
// each delivery is a memory read step (DRAIN) followed by an emit step (DELIVER).
// A result reaches res in the cycle after its emit step. If res stalls, the
// sequencer holds in its emit step; one finished result may wait in the output
// register while the next segment is accepted.
// Reset: expected 1, final 0, window 4, all slots empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receive_window_core #(
  parameter int WIN_MAX      = srrw_pkg::WIN_MAX_DEF,
  parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  srrw_cfg_if.sink    cfg,
  srrw_seg_if.sink    seg,
  srrw_res_if.source  res
);
  import srrw_pkg::*;

  localparam int SLOT_W = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int WS_W   = 7;
  localparam logic [WS_W-1:0]   WIN_MAX_WS   = WS_W'(WIN_MAX);
  localparam logic [SEQ_W-1:0]  WIN_MAX_SEQ  = SEQ_W'(WIN_MAX);
  localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(WIN_MAX - 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CMP_LO    = 9'b000000010,
    S_CMP_HI    = 9'b000000100,
    S_SLOT_ADD  = 9'b000001000,
    S_SLOT_WRAP = 9'b000010000,
    S_DRAIN     = 9'b000100000,
    S_DELIVER   = 9'b001000000,
    S_ACK       = 9'b010000000,
    S_TERM      = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]        window_size;
  logic [SEQ_W-1:0]        expected_seq;
  logic [SEQ_W-1:0]        final_seq;
  logic                    finished;
  logic [SLOT_W-1:0]       ptr;
  logic [SEQ_W-1:0]        seq_r;
  logic [PAYLOAD_BITS-1:0] data_r;
  logic                    stale;
  logic [SEQ_W-1:0]        offset;
  logic [SLOT_W:0]         tmp;

  logic                    out_valid;
  logic [KIND_W-1:0]       out_kind;
  logic [SEQ_W-1:0]        out_seq;
  logic [PAYLOAD_BITS-1:0] out_data;
  logic                    out_done;
  logic                    out_last;
  logic                    out_free;
  logic                    out_load;

  alu_req_t                alu_req;
  logic [ALU_W-1:0]        alu_res;
  logic                    alu_msb;
  logic                    alu_zero;
  logic [WS_W-1:0]         ws_eff;

  logic                    seg_take;
  logic                    st_en;
  logic [SLOT_W-1:0]       st_addr;
  logic                    rd_en;
  logic                    clr_en;
  logic                    ptr_vld;
  logic [PAYLOAD_BITS-1:0] rd_data;
  logic                    ack_done;

  srrw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  srrw_buf #(
    .WIN_MAX      (WIN_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SLOT_W       (SLOT_W)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .st_en   (st_en),
    .st_addr (st_addr),
    .st_data (data_r),
    .ptr     (ptr),
    .rd_en   (rd_en),
    .clr_en  (clr_en),
    .ptr_vld (ptr_vld),
    .rd_data (rd_data)
  );

  assign cfg.ready       = 1'b1;
  assign seg.ready       = (state == S_IDLE);
  assign seg_take        = seg.valid && seg.ready;
  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.result_seq  = out_seq;
  assign res.result_data = out_data;
  assign res.conn_done   = out_done;
  assign res.last_of_run = out_last;
  assign out_free        = !out_valid || res.ready;
  assign out_load        = out_free &&
                           ((state == S_DELIVER) || (state == S_ACK) || (state == S_TERM));

  assign alu_msb  = alu_res[ALU_W-1];
  assign alu_zero = (alu_res[SEQ_W-1:0] == '0);

  always_comb begin
    if ({{(WS_W-CFG_W){1'b0}}, window_size} > WIN_MAX_WS) begin
      ws_eff = WIN_MAX_WS;
    end else begin
      ws_eff = {{(WS_W-CFG_W){1'b0}}, window_size};
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = expected_seq;
    alu_req.b  = final_seq;
    unique case (state)
      S_CMP_LO: begin
        alu_req.a = seq_r;
        alu_req.b = expected_seq;
      end
      S_CMP_HI: begin
        alu_req.a = offset;
        alu_req.b = {{(SEQ_W-WS_W){1'b0}}, ws_eff};
      end
      S_SLOT_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {{(SEQ_W-SLOT_W){1'b0}}, ptr};
        alu_req.b  = offset;
      end
      S_SLOT_WRAP: begin
        alu_req.a = {{(SEQ_W-SLOT_W-1){1'b0}}, tmp};
        alu_req.b = WIN_MAX_SEQ;
      end
      S_DELIVER: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = SEQ_W'(1);
      end
      S_TERM: begin
        alu_req.b = seq_r;
      end
      S_IDLE, S_DRAIN, S_ACK: begin
        alu_req.b = final_seq;
      end
      default: begin
        alu_req.b = final_seq;
      end
    endcase
  end

  assign ack_done = !stale && alu_zero;
  assign st_en    = (state == S_SLOT_WRAP);
  assign st_addr  = alu_msb ? tmp[SLOT_W-1:0] : alu_res[SLOT_W-1:0];
  assign rd_en    = (state == S_DRAIN) && ptr_vld;
  assign clr_en   = (state == S_DELIVER) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (seg_take && !finished && seg.checksum_ok) begin
          state_next = (seg.req_type == REQ_TERM) ? S_TERM : S_CMP_LO;
        end
      end
      S_CMP_LO:    state_next = alu_msb ? S_ACK : S_CMP_HI;
      S_CMP_HI:    state_next = alu_msb ? S_SLOT_ADD : S_IDLE;
      S_SLOT_ADD:  state_next = S_SLOT_WRAP;
      S_SLOT_WRAP: state_next = S_DRAIN;
      S_DRAIN:     state_next = ptr_vld ? S_DELIVER : S_ACK;
      S_DELIVER:   state_next = out_free ? S_DRAIN : S_DELIVER;
      S_ACK:       state_next = out_free ? S_IDLE : S_ACK;
      S_TERM:      state_next = out_free ? S_IDLE : S_TERM;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window_size  <= WINDOW_RESET;
      expected_seq <= EXPECTED_RESET;
      final_seq    <= '0;
      finished     <= 1'b0;
      ptr          <= SLOT_W'(EXPECTED_RESET % WIN_MAX);
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        window_size <= cfg.window_size;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_DELIVER: begin
          if (out_free) begin
            expected_seq <= alu_res[SEQ_W-1:0];
            if (alu_zero || ptr == SLOT_LAST) begin
              ptr <= '0;
            end else begin
              ptr <= ptr + SLOT_W'(1);
            end
          end
        end
        S_ACK: begin
          if (out_free) begin
            if (ack_done) begin
              finished <= 1'b1;
            end
          end
        end
        S_TERM: begin
          if (out_free) begin
            final_seq <= seq_r;
            if (alu_zero) begin
              finished <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (seg_take) begin
      seq_r  <= seg.seq_num;
      data_r <= seg.payload;
      stale  <= 1'b0;
    end
    if (state == S_CMP_LO) begin
      stale  <= alu_msb;
      offset <= alu_res[SEQ_W-1:0];
    end
    if (state == S_SLOT_ADD) begin
      tmp <= alu_res[SLOT_W:0];
    end
    if (out_free) begin
      unique case (state)
        S_DELIVER: begin
          out_kind <= KIND_DELIVER;
          out_seq  <= expected_seq;
          out_data <= rd_data;
          out_done <= 1'b0;
          out_last <= 1'b0;
        end
        S_ACK: begin
          out_kind <= KIND_ACK;
          out_seq  <= seq_r;
          out_data <= '0;
          out_done <= ack_done;
          out_last <= 1'b1;
        end
        S_TERM: begin
          out_kind <= KIND_TERM_ACK;
          out_seq  <= seq_r;
          out_data <= '0;
          out_done <= alu_zero;
          out_last <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("finished flag cleared");

  a_deliver_from_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DELIVER) |-> ptr_vld)
    else $error("delivery from an empty slot");

  a_deliver_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_DELIVER) |-> (!out_done && !out_last))
    else $error("delivered payload flagged as done or last");

  a_ignore_after_done: assert property (@(posedge clk) disable iff (rst)
    (seg_take && finished) |=> (state == S_IDLE))
    else $error("segment processed after connection finished");
`endif

endmodule

`default_nettype wire

// ===== src/srrw_alu.sv =====
// Shared 17-bit add/subtract unit; bit 16 is carry on add, borrow on subtract.
// Depends on srrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srrw_alu (
  input  srrw_pkg::alu_req_t         req,
  output logic [srrw_pkg::ALU_W-1:0] res
);
  import srrw_pkg::*;

  logic [ALU_W-1:0] a_ext;
  logic [ALU_W-1:0] b_ext;

  assign a_ext = {1'b0, req.a};
  assign b_ext = {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      ALU_ADD: res = a_ext + b_ext;
      ALU_SUB: res = a_ext - b_ext;
      default: res = a_ext - b_ext;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/srrw_buf.sv =====
// Reorder buffer: per-slot valid flags and the payload memory with registered read.
// Depends on srrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srrw_buf #(
  parameter int WIN_MAX      = srrw_pkg::WIN_MAX_DEF,
  parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF,
  parameter int SLOT_W       = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    st_en,
  input  logic [SLOT_W-1:0]       st_addr,
  input  logic [PAYLOAD_BITS-1:0] st_data,
  input  logic [SLOT_W-1:0]       ptr,
  input  logic                    rd_en,
  input  logic                    clr_en,
  output logic                    ptr_vld,
  output logic [PAYLOAD_BITS-1:0] rd_data
);
  import srrw_pkg::*;

  logic [WIN_MAX-1:0]      vld;
  logic [PAYLOAD_BITS-1:0] mem [WIN_MAX];
  logic                    st_new;

  assign st_new  = st_en && !vld[st_addr];
  assign ptr_vld = vld[ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (st_new) begin
        vld[st_addr] <= 1'b1;
      end
      if (clr_en) begin
        vld[ptr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_new) begin
      mem[st_addr] <= st_data;
    end
    if (rd_en) begin
      rd_data <= mem[ptr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/srrw_window_monitor.sv =====
// Checker for the selective-repeat receive window: tracks window state from the
// segment and config transactions and compares every result transaction.
// Depends on srrw_pkg and srrw_if.
`timescale 1ns / 1ps

module srrw_window_monitor #(
  parameter int WIN_MAX      = srrw_pkg::WIN_MAX_DEF,
  parameter int PAYLOAD_BITS = srrw_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  srrw_cfg_if                        cfg,
  srrw_seg_if                        seg,
  srrw_res_if                        res,
  output int unsigned                fault_count,
  output int unsigned                owed_count,
  output logic [srrw_pkg::SEQ_W-1:0] model_next_seq
);
  import srrw_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] data;
    logic                    done;
    logic                    last;
  } rx_result_t;

  rx_result_t              owed_results[$];
  logic [CFG_W-1:0]        win_reg;
  logic [SEQ_W-1:0]        exp_seq;
  logic [SEQ_W-1:0]        fin_seq;
  logic [WIN_MAX-1:0]      slot_full;
  logic [PAYLOAD_BITS-1:0] slot_word [WIN_MAX];
  logic                    closed;
  int unsigned             bad_fields = 0;

  function automatic void owe(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] sq,
                              input logic [PAYLOAD_BITS-1:0] word, input logic done,
                              input logic last);
    owed_results.push_back('{kind, sq, word, done, last});
  endfunction

  task automatic receive_segment(input logic is_term, input logic [SEQ_W-1:0] sq,
                                 input logic [PAYLOAD_BITS-1:0] word, input logic ok);
    int unsigned ws;
    int unsigned lim;
    int unsigned slot;
    int unsigned n;
    logic        closes;
    if (closed || !ok) return;
    if (is_term == REQ_TERM) begin
      fin_seq = sq;
      closes  = (exp_seq == fin_seq);
      if (closes) closed = 1'b1;
      owe(KIND_TERM_ACK, sq, '0, closes, 1'b1);
      return;
    end
    if (sq < exp_seq) begin
      owe(KIND_ACK, sq, '0, 1'b0, 1'b1);
      return;
    end
    ws  = (win_reg > WIN_MAX) ? WIN_MAX : win_reg;
    lim = 32'(exp_seq) + ws;
    if (32'(sq) >= lim) return;
    slot = sq % WIN_MAX;
    if (!slot_full[slot]) begin
      slot_full[slot] = 1'b1;
      slot_word[slot] = word;
    end
    n = 0;
    while (n < WIN_MAX && slot_full[exp_seq % WIN_MAX]) begin
      slot = exp_seq % WIN_MAX;
      owe(KIND_DELIVER, exp_seq, slot_word[slot], 1'b0, 1'b0);
      slot_full[slot] = 1'b0;
      exp_seq = exp_seq + 1'b1;
      n++;
    end
    closes = (exp_seq == fin_seq);
    if (closes) closed = 1'b1;
    owe(KIND_ACK, sq, '0, closes, 1'b1);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      bad_fields++;
    end
  endtask

  task automatic check_result();
    rx_result_t want;
    if (owed_results.size() == 0) begin
      $error("result_kind: expected none, actual %0h (result_seq %0h)",
             res.result_kind, res.result_seq);
      bad_fields++;
    end else begin
      want = owed_results.pop_front();
      check_field("result_kind", 64'(want.kind), 64'(res.result_kind));
      check_field("result_seq", 64'(want.seq), 64'(res.result_seq));
      check_field("result_data", 64'(want.data), 64'(res.result_data));
      check_field("conn_done", 64'(want.done), 64'(res.conn_done));
      check_field("last_of_run", 64'(want.last), 64'(res.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_reg   = WINDOW_RESET;
      exp_seq   = EXPECTED_RESET;
      fin_seq   = '0;
      slot_full = '0;
      closed    = 1'b0;
      owed_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) win_reg = cfg.window_size;
      if (seg.valid && seg.ready)
        receive_segment(seg.req_type, seg.seq_num, seg.payload, seg.checksum_ok);
      if (res.valid && res.ready) check_result();
    end
    owed_count     <= owed_results.size();
    model_next_seq <= exp_seq;
    fault_count    <= bad_fields;
  end

endmodule

// ===== tb/tb_selective_repeat_receive_window_core.sv =====
// Testbench top for selective_repeat_receive_window_core: clock, reset, segment
// and config stimulus, result backpressure and the verdict.
// Depends on srrw_pkg, srrw_if, the core RTL and srrw_window_monitor.
`timescale 1ns / 1ps

module tb_selective_repeat_receive_window_core;
  import srrw_pkg::*;

  localparam int SETTLE_CYCLES   = 30;
  localparam int IDLE_LIMIT      = 2000;
  localparam int FULL_RATE_ITEMS = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  int unsigned       fault_count;
  int unsigned       owed_count;
  logic [SEQ_W-1:0]  model_next_seq;
  logic [SEQ_W-1:0]  cur;
  int unsigned       wnd_eff;
  int unsigned       burst_left = 0;
  bit                pace_on = 1'b1;
  bit                rx_stall_on = 1'b1;
  int unsigned       rx_hold = 0;
  int unsigned       rx_mode;
  int unsigned       quiet_cycles = 0;

  srrw_seg_if seg_ch ();
  srrw_res_if res_ch ();
  srrw_cfg_if cfg_ch ();

  selective_repeat_receive_window_core dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .seg (seg_ch),
    .res (res_ch)
  );

  srrw_window_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_ch),
    .seg            (seg_ch),
    .res            (res_ch),
    .fault_count    (fault_count),
    .owed_count     (owed_count),
    .model_next_seq (model_next_seq)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result backpressure: long open stretches, short stalls, choppy patches
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rx_stall_on) begin
        res_ch.ready <= 1'b1;
      end else if (rx_hold != 0) begin
        rx_hold--;
      end else begin
        rx_mode = $urandom_range(0, 9);
        res_ch.ready <= (rx_mode < 2) || (rx_mode >= 5);
        rx_hold = (rx_mode < 2) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      end
    end
  end

  task automatic send_seg(input logic kind, input logic [SEQ_W-1:0] sq,
                          input logic [31:0] word, input logic ok);
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) begin
          seg_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      burst_left--;
    end
    seg_ch.valid       <= 1'b1;
    seg_ch.req_type    <= kind;
    seg_ch.seq_num     <= sq;
    seg_ch.payload     <= word;
    seg_ch.checksum_ok <= ok;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  // hold off until every owed result is out, then pick up the true window base
  task automatic settle();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cur = model_next_seq;
  endtask

  task automatic set_window(input logic [CFG_W-1:0] v);
    settle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    wnd_eff = (v > WIN_MAX_DEF) ? WIN_MAX_DEF : v;
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned      sent;
    int unsigned      pick;
    int unsigned      k;
    int unsigned      m;
    int unsigned      j;
    int unsigned      lo;
    logic             ok;
    logic [SEQ_W-1:0] grp [WIN_MAX_DEF];
    logic [SEQ_W-1:0] t;
    logic [SEQ_W-1:0] sq;
    bit               broken;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 && wnd_eff > 0) begin
        k = $urandom_range(1, wnd_eff);
        for (int i = 0; i < k; i++) grp[i] = SEQ_W'(cur + i);
        for (int i = k - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = grp[i];
          grp[i] = grp[j];
          grp[j] = t;
        end
        broken = (k > 1) && ($urandom_range(0, 9) == 0);
        m = $urandom_range(0, k - 1);
        for (int i = 0; i < k; i++) begin
          if (!(broken && i == m)) begin
            send_seg(REQ_DATA, grp[i], $urandom, 1'b1);
            sent++;
          end
          if ($urandom_range(0, 7) == 0) begin
            ok = 1'($urandom_range(0, 1));
            send_seg(REQ_DATA, grp[$urandom_range(0, i)], $urandom, ok);
            if (ok) sent++;
          end
        end
        cur = broken ? grp[m] : SEQ_W'(cur + k);
      end else if (pick < 80) begin
        send_seg(1'($urandom_range(0, 1)), SEQ_W'($urandom), $urandom, 1'b0);
      end else if (pick < 86 && cur > 0) begin
        send_seg(REQ_DATA, SEQ_W'($urandom_range(0, cur - 1)), $urandom, 1'b1);
        sent++;
      end else if (pick < 93) begin
        lo = cur + wnd_eff;
        send_seg(REQ_DATA, SEQ_W'($urandom_range(lo, 65535)), $urandom, 1'b1);
        sent++;
      end else begin
        // final number kept behind or far ahead so the connection stays open
        if (cur > 1 && $urandom_range(0, 1) == 1) sq = SEQ_W'($urandom_range(0, cur - 1));
        else sq = SEQ_W'($urandom_range(cur + 1000, 65535));
        send_seg(REQ_TERM, sq, $urandom, 1'b1);
        sent++;
      end
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  initial begin
    seg_ch.valid       = 1'b0;
    seg_ch.req_type    = REQ_DATA;
    seg_ch.seq_num     = '0;
    seg_ch.payload     = '0;
    seg_ch.checksum_ok = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.window_size = WINDOW_RESET;
    wnd_eff            = WINDOW_RESET;
    cur                = EXPECTED_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_seg(REQ_DATA, 16'd1, 32'hFFFF_FFFF, 1'b1);
    send_seg(REQ_DATA, 16'd3, 32'h0000_0000, 1'b1);
    send_seg(REQ_DATA, 16'd3, 32'h1234_5678, 1'b1);
    send_seg(REQ_DATA, 16'd0, 32'hA5A5_A5A5, 1'b1);
    send_seg(REQ_DATA, 16'd2, 32'hDEAD_BEEF, 1'b0);
    send_seg(REQ_DATA, 16'd6, 32'h0BAD_0BAD, 1'b1);
    send_seg(REQ_DATA, 16'hFFFF, 32'h0BAD_0BAD, 1'b1);
    send_seg(REQ_DATA, 16'd5, 32'h5555_5555, 1'b1);
    send_seg(REQ_DATA, 16'd2, 32'hAAAA_AAAA, 1'b1);
    send_seg(REQ_TERM, 16'd0, 32'h0000_0000, 1'b0);
    send_seg(REQ_TERM, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_seg(REQ_DATA, 16'd4, 32'h0F0F_0F0F, 1'b1);
    set_window(4'd0);
    send_seg(REQ_DATA, 16'd6, 32'h7777_7777, 1'b1);
    send_seg(REQ_DATA, 16'd5, 32'h8888_8888, 1'b1);
    set_window(4'hF);
    send_seg(REQ_DATA, cur + 16'd8, $urandom, 1'b1);
    for (int s = 7; s >= 1; s--) send_seg(REQ_DATA, cur + 16'(s), $urandom, 1'b1);
    send_seg(REQ_DATA, cur, $urandom, 1'b1);

    set_window(4'd8);
    run_random(40);
    set_window(4'd1);
    run_random(20);
    set_window(4'd3);
    run_random(30);
    set_window(CFG_W'($urandom_range(0, 15)));
    run_random(30);

    // in-order stream back to back with the receiver always ready
    set_window(4'd8);
    send_seg(REQ_TERM, 16'd0, $urandom, 1'b1);
    pace_on     = 1'b0;
    rx_stall_on = 1'b0;
    repeat (FULL_RATE_ITEMS) begin
      send_seg(REQ_DATA, cur, $urandom, 1'b1);
      cur++;
    end
    set_window(4'd4);
    pace_on     = 1'b1;
    rx_stall_on = 1'b1;
    send_seg(REQ_TERM, 16'd30000, $urandom, 1'b1);
    send_seg(REQ_DATA, 16'hFFFF, $urandom, 1'b1);
    send_seg(REQ_DATA, 16'hFFFE, $urandom, 1'b1);
    send_seg(REQ_DATA, 16'hFFFC, $urandom, 1'b1);
    send_seg(REQ_DATA, 16'hFFFD, $urandom, 1'b1);
    send_seg(REQ_DATA, 16'h0000, $urandom, 1'b1);

    set_window(4'd5);
    run_random(40);
    set_window(4'd6);
    run_random(30);

    // close the connection on an ack, then check that later segments are dropped
    set_window(4'd8);
    for (int s = 1; s < 8; s++) send_seg(REQ_DATA, cur + 16'(s), $urandom, 1'b1);
    send_seg(REQ_TERM, cur + 16'd8, $urandom, 1'b1);
    send_seg(REQ_DATA, cur, $urandom, 1'b1);
    send_seg(REQ_DATA, cur + 16'd8, $urandom, 1'b1);
    send_seg(REQ_TERM, cur + 16'd8, $urandom, 1'b1);
    send_seg(REQ_DATA, cur, $urandom, 1'b1);
    settle();

    if (fault_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
